[hdl/dcr_pkg.sv]
`timescale 1ns / 1ps
package dcr_pkg;

	localparam int FRAC_BITS = 16;
	// eps = round(0.0001 * 2^FRAC_BITS), at least 1
	localparam int EPS_RAW = (((1 << FRAC_BITS) + 5000) / 10000)
		+ (((1 << FRAC_BITS) < 5000) ? 1 : 0);

	localparam int RAD_W     = 68;  // squared distance, padded to even
	localparam int ROOT_W    = 34;
	localparam int SQ_STEPS  = RAD_W / 2;
	localparam int DEN_W     = 35;
	localparam int NUM_W     = 64;
	localparam int DIV_STEPS = NUM_W;

	// link data carried alongside the arithmetic
	typedef struct packed {
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic               pa;
		logic               pb;
		logic               brk_en;
		logic               broken;
		logic               now;
		logic        [30:0] rest;
		logic        [30:0] brk;
		logic        [32:0] mx;
		logic        [32:0] my;
		logic               nx;
		logic               ny;
	} meta_t;

	typedef struct packed {
		logic signed [31:0] new_a_x;
		logic signed [31:0] new_a_y;
		logic signed [31:0] new_b_x;
		logic signed [31:0] new_b_y;
		logic               broken_out;
		logic               broke_now;
	} res_t;

	// saturate a 65 bit signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
		logic hi_ok;
		hi_ok = (v[64:31] == '0) || (v[64:31] == '1);
		if (hi_ok)
			return v[31:0];
		else if (v[64])
			return 32'sh8000_0000;
		else
			return 32'sh7fff_ffff;
	endfunction

endpackage

[hdl/dcr_isqrt.sv]
`timescale 1ns / 1ps
// Pipelined floor square root, two radicand bits per stage.
module dcr_isqrt import dcr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_v,
	input  logic [RAD_W-1:0]  rad,
	input  meta_t             meta_in,
	output logic              out_v,
	output logic [ROOT_W-1:0] root,
	output meta_t             meta_out
);

	logic [RAD_W-1:0]  rad_s  [0:SQ_STEPS];
	logic [36:0]       rem_s  [0:SQ_STEPS];
	logic [ROOT_W-1:0] root_s [0:SQ_STEPS];
	meta_t             meta_s [0:SQ_STEPS];
	logic              v_s    [0:SQ_STEPS];

	assign rad_s[0]  = rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign meta_s[0] = meta_in;
	assign v_s[0]    = in_v;

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
		logic [36:0] rem_sh;
		logic [36:0] trial;
		logic        fit;

		// bring down two bits, try root*4+1
		always_comb begin
			rem_sh = {rem_s[k][34:0], rad_s[k][RAD_W-1 -: 2]};
			trial  = {1'b0, root_s[k], 2'b01};
			fit    = rem_sh >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1]  <= {rad_s[k][RAD_W-3:0], 2'b00};
				rem_s[k+1]  <= fit ? rem_sh - trial : rem_sh;
				root_s[k+1] <= {root_s[k][ROOT_W-2:0], fit};
				meta_s[k+1] <= meta_s[k];
			end
		end
	end

	assign out_v    = v_s[SQ_STEPS];
	assign root     = root_s[SQ_STEPS];
	assign meta_out = meta_s[SQ_STEPS];

endmodule

[hdl/dcr_div.sv]
`timescale 1ns / 1ps
// Pipelined restoring divider, two numerators over one divisor, one bit a stage.
// The numerator register turns into the quotient as bits shift out.
module dcr_div import dcr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_v,
	input  logic [NUM_W-1:0] num_x,
	input  logic [NUM_W-1:0] num_y,
	input  logic [DEN_W-1:0] den,
	input  meta_t            meta_in,
	output logic             out_v,
	output logic [NUM_W-1:0] quo_x,
	output logic [NUM_W-1:0] quo_y,
	output meta_t            meta_out
);

	logic [NUM_W-1:0] nx_s   [0:DIV_STEPS];
	logic [NUM_W-1:0] ny_s   [0:DIV_STEPS];
	logic [DEN_W:0]   rx_s   [0:DIV_STEPS];
	logic [DEN_W:0]   ry_s   [0:DIV_STEPS];
	logic [DEN_W-1:0] den_s  [0:DIV_STEPS];
	meta_t            meta_s [0:DIV_STEPS];
	logic             v_s    [0:DIV_STEPS];

	assign nx_s[0]   = num_x;
	assign ny_s[0]   = num_y;
	assign rx_s[0]   = '0;
	assign ry_s[0]   = '0;
	assign den_s[0]  = den;
	assign meta_s[0] = meta_in;
	assign v_s[0]    = in_v;

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [DEN_W:0] shx, shy;
		logic           fx, fy;

		always_comb begin
			shx = {rx_s[k][DEN_W-1:0], nx_s[k][NUM_W-1]};
			shy = {ry_s[k][DEN_W-1:0], ny_s[k][NUM_W-1]};
			fx  = shx >= {1'b0, den_s[k]};
			fy  = shy >= {1'b0, den_s[k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rx_s[k+1]   <= fx ? shx - {1'b0, den_s[k]} : shx;
				ry_s[k+1]   <= fy ? shy - {1'b0, den_s[k]} : shy;
				nx_s[k+1]   <= {nx_s[k][NUM_W-2:0], fx};
				ny_s[k+1]   <= {ny_s[k][NUM_W-2:0], fy};
				den_s[k+1]  <= den_s[k];
				meta_s[k+1] <= meta_s[k];
			end
		end
	end

	assign out_v    = v_s[DIV_STEPS];
	assign quo_x    = nx_s[DIV_STEPS];
	assign quo_y    = ny_s[DIV_STEPS];
	assign meta_out = meta_s[DIV_STEPS];

endmodule

[hdl/distance_constraint_relax.sv]
`timescale 1ns / 1ps
// Channel   Handshake              Words
// in        in_valid / in_ready    end_a_*, end_b_*, pins, rest/break length, flags
// out       out_valid / out_ready  new_a_*, new_b_*, broken_out, broke_now
//
// One link per cycle while the pipeline is not held. To the output register:
// three stages of difference/square/sum, 34 square root stages, one scale
// stage, 64 divider stages, two combine stages.
// arst_n clears all valid bits; data registers are not reset.
// A one-word output register plus a skid word keeps input open while a result waits;
// the whole pipeline holds only while the skid word is occupied.
module distance_constraint_relax import dcr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] end_a_x,
	input  logic signed [31:0] end_a_y,
	input  logic signed [31:0] end_b_x,
	input  logic signed [31:0] end_b_y,
	input  logic               end_a_pinned,
	input  logic               end_b_pinned,
	input  logic        [30:0] rest_length,
	input  logic        [30:0] break_length,
	input  logic               breakable,
	input  logic               broken_in,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] new_a_x,
	output logic signed [31:0] new_a_y,
	output logic signed [31:0] new_b_x,
	output logic signed [31:0] new_b_y,
	output logic               broken_out,
	output logic               broke_now
);

	logic en;
	logic skid_v_q, out_v_q;
	res_t skid_q, out_q;

	assign en       = !skid_v_q;
	assign in_ready = en;

	// stage 1: differences and magnitudes
	meta_t       meta_s1;
	meta_t       meta_d1;
	logic        v_s1;
	logic signed [32:0] dx, dy;

	always_comb begin
		dx = {end_b_x[31], end_b_x} - {end_a_x[31], end_a_x};
		dy = {end_b_y[31], end_b_y} - {end_a_y[31], end_a_y};
		meta_d1.ax     = end_a_x;
		meta_d1.ay     = end_a_y;
		meta_d1.bx     = end_b_x;
		meta_d1.by     = end_b_y;
		meta_d1.pa     = end_a_pinned;
		meta_d1.pb     = end_b_pinned;
		meta_d1.brk_en = breakable;
		meta_d1.broken = broken_in;
		meta_d1.now    = 1'b0;
		meta_d1.rest   = rest_length;
		meta_d1.brk    = break_length;
		meta_d1.mx     = dx[32] ? 33'(-dx) : 33'(dx);
		meta_d1.my     = dy[32] ? 33'(-dy) : 33'(dy);
		meta_d1.nx     = dx[32];
		meta_d1.ny     = dy[32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s1 <= meta_d1;
		end
	end

	// stage 2: squares; a magnitude of 2^32 has zero low bits
	meta_t       meta_s2;
	logic        v_s2;
	logic [65:0] sqx_s2, sqy_s2;
	logic [63:0] px, py;

	always_comb begin
		px = meta_s1.mx[31:0] * meta_s1.mx[31:0];
		py = meta_s1.my[31:0] * meta_s1.my[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s2 <= meta_s1;
			sqx_s2  <= meta_s1.mx[32] ? {2'b01, 64'd0} : {2'b00, px};
			sqy_s2  <= meta_s1.my[32] ? {2'b01, 64'd0} : {2'b00, py};
		end
	end

	// stage 3: squared distance
	meta_t            meta_s3;
	logic             v_s3;
	logic [RAD_W-1:0] rad_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s3 <= meta_s2;
			rad_s3  <= {2'b00, sqx_s2} + {2'b00, sqy_s2};
		end
	end

	// square root pipeline
	logic              sq_v;
	logic [ROOT_W-1:0] sq_root;
	meta_t             sq_meta;

	dcr_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s3),
		.rad      (rad_s3),
		.meta_in  (meta_s3),
		.out_v    (sq_v),
		.root     (sq_root),
		.meta_out (sq_meta)
	);

	// stage 4: break test, divisor, scaled numerators
	meta_t            meta_s4;
	meta_t            meta_d4;
	logic             v_s4;
	logic [DEN_W-1:0] den_s4;
	logic [NUM_W-1:0] numx_s4, numy_s4;
	logic [NUM_W-1:0] qx_p, qy_p;

	always_comb begin
		qx_p        = sq_meta.mx[31:0] * sq_meta.rest;
		qy_p        = sq_meta.my[31:0] * sq_meta.rest;
		meta_d4     = sq_meta;
		meta_d4.now = sq_meta.brk_en && !sq_meta.broken
			&& (sq_root >= {3'b000, sq_meta.brk});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= sq_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s4 <= meta_d4;
			den_s4  <= {1'b0, sq_root} + DEN_W'(EPS_RAW);
			numx_s4 <= sq_meta.mx[32] ? {1'b0, sq_meta.rest, 32'd0} : qx_p;
			numy_s4 <= sq_meta.my[32] ? {1'b0, sq_meta.rest, 32'd0} : qy_p;
		end
	end

	// divider pipeline
	logic             dv_v;
	logic [NUM_W-1:0] qx, qy;
	meta_t            dv_meta;

	dcr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s4),
		.num_x    (numx_s4),
		.num_y    (numy_s4),
		.den      (den_s4),
		.meta_in  (meta_s4),
		.out_v    (dv_v),
		.quo_x    (qx),
		.quo_y    (qy),
		.meta_out (dv_meta)
	);

	// stage 5: midpoint sums minus/plus offset, doubled
	meta_t              meta_s5;
	logic               v_s5;
	logic signed [65:0] tax_s5, tay_s5, tbx_s5, tby_s5;
	logic signed [65:0] sumx, sumy, ox, oy;

	always_comb begin
		sumx = 66'(dv_meta.ax) + 66'(dv_meta.bx);
		sumy = 66'(dv_meta.ay) + 66'(dv_meta.by);
		ox   = dv_meta.nx ? -$signed({2'b00, qx}) : $signed({2'b00, qx});
		oy   = dv_meta.ny ? -$signed({2'b00, qy}) : $signed({2'b00, qy});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= dv_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s5 <= dv_meta;
			tax_s5  <= sumx - ox;
			tay_s5  <= sumy - oy;
			tbx_s5  <= sumx + ox;
			tby_s5  <= sumy + oy;
		end
	end

	// stage 6: floor halve, saturate, pin and broken pass-through
	res_t res_s6;
	res_t res_d6;
	logic v_s6;
	logic keep_a, keep_b;

	always_comb begin
		keep_a            = meta_s5.broken || meta_s5.pa;
		keep_b            = meta_s5.broken || meta_s5.pb;
		res_d6.new_a_x    = keep_a ? meta_s5.ax : sat32(tax_s5[65:1]);
		res_d6.new_a_y    = keep_a ? meta_s5.ay : sat32(tay_s5[65:1]);
		res_d6.new_b_x    = keep_b ? meta_s5.bx : sat32(tbx_s5[65:1]);
		res_d6.new_b_y    = keep_b ? meta_s5.by : sat32(tby_s5[65:1]);
		res_d6.broken_out = meta_s5.broken || meta_s5.now;
		res_d6.broke_now  = meta_s5.now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s6 <= res_d6;
		end
	end

	// output word and skid word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || out_ready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= v_s6;
			end
		end else if (v_s6 && en) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || out_ready) begin
			out_q <= skid_v_q ? skid_q : res_s6;
		end else if (v_s6 && en) begin
			skid_q <= res_s6;
		end
	end

	assign out_valid  = out_v_q;
	assign new_a_x    = out_q.new_a_x;
	assign new_a_y    = out_q.new_a_y;
	assign new_b_x    = out_q.new_b_x;
	assign new_b_y    = out_q.new_b_y;
	assign broken_out = out_q.broken_out;
	assign broke_now  = out_q.broke_now;

endmodule

[hdl/dcr_checker.sv]
`timescale 1ns / 1ps
module dcr_assertions (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] new_a_x,
	input logic signed [31:0] new_b_y,
	input logic               broken_out,
	input logic               broke_now
);

	// a held result word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(new_a_x)
		&& $stable(new_b_y) && $stable(broke_now))
		else $error("output word changed while stalled");

	// a fresh break always reports the link as broken
	a_break_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && broke_now |-> broken_out)
		else $error("broke_now without broken_out");

	// input closes only behind an output stall
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> $past(out_valid && !out_ready))
		else $error("input closed without output back-pressure");

endmodule

bind distance_constraint_relax dcr_assertions u_dcr_assertions (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.new_a_x    (new_a_x),
	.new_b_y    (new_b_y),
	.broken_out (broken_out),
	.broke_now  (broke_now)
);
